// File: hw/rtl/ring_queue_with_overflow_refill_assert.svh
// Assertion macros used by the ring queue checker.
// Needs nothing else; the including file supplies clock, reset and expressions.
`ifndef RING_QUEUE_WITH_OVERFLOW_REFILL_ASSERT_SVH
`define RING_QUEUE_WITH_OVERFLOW_REFILL_ASSERT_SVH

// same-cycle implication
`define RQOR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ring queue check failed");

// next-cycle implication
`define RQOR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring queue check failed");

`endif

// File: hw/rtl/rqor_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the ring queue with overflow refill. No dependencies.
package rqor_pkg;

  localparam int CFG_BITS      = 5;
  localparam int FUNC_BITS     = 3;
  localparam int STAT_BITS     = 2;
  localparam int TAG_PORT_BITS = 32;
  localparam int TIME_BITS     = 16;
  localparam int COUNT_BITS    = 5;
  localparam int DUMP_LIMIT    = 16;

  localparam logic [CFG_BITS-1:0] CAP_RESET = 5'd16;

  localparam logic [FUNC_BITS-1:0] FUNC_ENQ    = 3'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_DEQ    = 3'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_REFILL = 3'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_DUMP   = 3'd3;

  localparam logic [STAT_BITS-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_DIVERT = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_LOST   = 2'd2;
  localparam logic [STAT_BITS-1:0] STAT_EMPTY  = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
    logic spill_rd;
    logic refill_wr;
    logic head_rd;
    logic dump_rd;
    logic dump_next;
    logic emit;
    logic emit_dump;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic                 can_push;
    logic                 spill_any;
    logic                 main_empty;
    logic                 dump_last;
    logic                 out_free;
  } sts_t;

endpackage

// File: hw/rtl/rqor_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rqor_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/rqor_ctrl.sv
// Controller state machine for the ring queue: sequences execute, refill,
// front read and dump steps. Depends on rqor_pkg.
module rqor_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rqor_pkg::sts_t sts_i,
  output rqor_pkg::cmd_t cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_EXEC      = 8'b0000_0010,
    ST_SPILL_RD  = 8'b0000_0100,
    ST_REFILL_WR = 8'b0000_1000,
    ST_FRONT_RD  = 8'b0001_0000,
    ST_FRONT_OUT = 8'b0010_0000,
    ST_DUMP_RD   = 8'b0100_0000,
    ST_DUMP_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.func == rqor_pkg::FUNC_REFILL) begin
          state_d = ST_SPILL_RD;
        end else if (sts_i.func == rqor_pkg::FUNC_DUMP && !sts_i.main_empty) begin
          state_d = ST_DUMP_RD;
        end else begin
          state_d = ST_FRONT_RD;
        end
      end
      ST_SPILL_RD: begin
        if (sts_i.spill_any && sts_i.can_push) begin
          cmd_o.spill_rd = 1'b1;
          state_d        = ST_REFILL_WR;
        end else begin
          state_d = ST_FRONT_RD;
        end
      end
      ST_REFILL_WR: begin
        cmd_o.refill_wr = 1'b1;
        state_d         = ST_SPILL_RD;
      end
      ST_FRONT_RD: begin
        cmd_o.head_rd = 1'b1;
        state_d       = ST_FRONT_OUT;
      end
      ST_FRONT_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_DUMP_RD: begin
        cmd_o.dump_rd = 1'b1;
        state_d       = ST_DUMP_OUT;
      end
      ST_DUMP_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_dump = 1'b1;
          if (sts_i.dump_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.dump_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// File: hw/rtl/rqor_dp.sv
// Datapath of the ring queue: pointers, counts, capacity register, the main
// and overflow RAMs and the output register. Depends on rqor_pkg, rqor_ram.
module rqor_dp #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int OVERFLOW_DEPTH = 16,
  parameter int TAG_BITS       = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rqor_pkg::CFG_BITS-1:0]        cfg_wdata_i,
  input  logic [rqor_pkg::FUNC_BITS-1:0]       func_i,
  input  logic [rqor_pkg::TAG_PORT_BITS-1:0]   passenger_tag_i,
  input  logic [rqor_pkg::TIME_BITS-1:0]       service_time_i,
  input  rqor_pkg::cmd_t                       cmd_i,
  output rqor_pkg::sts_t                       sts_o,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [rqor_pkg::STAT_BITS-1:0]       status_o,
  output logic                                 front_valid_o,
  output logic [rqor_pkg::TAG_PORT_BITS-1:0]   front_tag_o,
  output logic [rqor_pkg::TIME_BITS-1:0]       front_time_o,
  output logic [rqor_pkg::COUNT_BITS-1:0]      queue_count_o,
  output logic [rqor_pkg::COUNT_BITS-1:0]      overflow_count_o,
  output logic [rqor_pkg::TAG_PORT_BITS-1:0]   dump_tag_o,
  output logic                                 last_o
);

  localparam int TagW    = (TAG_BITS < rqor_pkg::TAG_PORT_BITS) ? TAG_BITS
                                                                : rqor_pkg::TAG_PORT_BITS;
  localparam int TagOutW = rqor_pkg::TAG_PORT_BITS;
  localparam int TimeW   = rqor_pkg::TIME_BITS;
  localparam int MainW   = TagW + TimeW;
  localparam int QAW     = $clog2(QUEUE_DEPTH);
  localparam int QCW     = $clog2(QUEUE_DEPTH + 1);
  localparam int SAW     = (OVERFLOW_DEPTH > 1) ? $clog2(OVERFLOW_DEPTH) : 1;
  localparam int SCW     = $clog2(OVERFLOW_DEPTH + 1);
  localparam int SSW     = SCW + 1;
  localparam int CfgW    = rqor_pkg::CFG_BITS;
  localparam int CmpW    = (QCW > CfgW) ? QCW : CfgW;
  localparam int DIW     = $clog2(rqor_pkg::DUMP_LIMIT);
  localparam int LW      = (QCW > DIW + 1) ? QCW : DIW + 1;
  localparam int CntOutW = rqor_pkg::COUNT_BITS;

  logic [CfgW-1:0]                    cap_q, cap_d;
  logic [rqor_pkg::FUNC_BITS-1:0]     func_q;
  logic [TagW-1:0]                    tag_q;
  logic [TimeW-1:0]                   time_q;
  logic [QAW-1:0]                     head_q, head_d, tail_q, tail_d;
  logic [QCW-1:0]                     mcnt_q, mcnt_d;
  logic [SAW-1:0]                     shead_q, shead_d;
  logic [SCW-1:0]                     scnt_q, scnt_d;
  logic [rqor_pkg::STAT_BITS-1:0]     status_q, status_d;
  logic [QAW-1:0]                     dump_addr_q, dump_addr_d;
  logic [DIW-1:0]                     dump_idx_q, dump_idx_d;
  logic                               out_valid_q, out_valid_d;
  logic [TagW-1:0]                    front_tag_q;
  logic [TimeW-1:0]                   front_time_q;

  logic [rqor_pkg::STAT_BITS-1:0]     out_status_q;
  logic                               out_fvalid_q;
  logic [TagW-1:0]                    out_ftag_q;
  logic [TimeW-1:0]                   out_ftime_q;
  logic [QCW-1:0]                     out_mcnt_q;
  logic [SCW-1:0]                     out_scnt_q;
  logic [TagW-1:0]                    out_dtag_q;
  logic                               out_last_q;

  logic [CmpW-1:0]  cap_eff;
  logic             can_push, spill_space, spill_any, main_empty, dump_last, out_free;
  logic [QAW-1:0]   head_inc, tail_inc, dump_addr_inc;
  logic [SAW-1:0]   shead_inc, stail;
  logic [SSW-1:0]   ssum;
  logic             is_enq;

  logic             m_we, m_re;
  logic [QAW-1:0]   m_raddr;
  logic [MainW-1:0] m_wdata, m_rdata;
  logic             s_we;
  logic [TagW-1:0]  s_rdata;
  logic [TagW-1:0]  rd_tag, sel_ftag;
  logic [TimeW-1:0] rd_time, sel_ftime;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CmpW'(1);
    end else if (CmpW'(cap_q) > CmpW'(QUEUE_DEPTH)) begin
      cap_eff = CmpW'(QUEUE_DEPTH);
    end else begin
      cap_eff = CmpW'(cap_q);
    end
  end

  assign can_push    = CmpW'(mcnt_q) < cap_eff;
  assign spill_space = scnt_q != SCW'(OVERFLOW_DEPTH);
  assign spill_any   = scnt_q != '0;
  assign main_empty  = mcnt_q == '0;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign is_enq      = func_q == rqor_pkg::FUNC_ENQ;
  assign dump_last   = (LW'(dump_idx_q) + LW'(1) == LW'(mcnt_q)) ||
                       (dump_idx_q == DIW'(rqor_pkg::DUMP_LIMIT - 1));

  assign head_inc      = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc      = (tail_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign dump_addr_inc = (dump_addr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : dump_addr_q + 1'b1;
  assign shead_inc     = (shead_q == SAW'(OVERFLOW_DEPTH - 1)) ? '0 : shead_q + 1'b1;
  assign ssum          = SSW'(shead_q) + SSW'(scnt_q);
  assign stail         = (ssum >= SSW'(OVERFLOW_DEPTH)) ? SAW'(ssum - SSW'(OVERFLOW_DEPTH))
                                                        : SAW'(ssum);

  assign sts_o.func       = func_q;
  assign sts_o.can_push   = can_push;
  assign sts_o.spill_any  = spill_any;
  assign sts_o.main_empty = main_empty;
  assign sts_o.dump_last  = dump_last;
  assign sts_o.out_free   = out_free;

  // RAM ports
  assign m_we    = (cmd_i.exec && is_enq && can_push) || cmd_i.refill_wr;
  assign m_wdata = cmd_i.refill_wr ? {s_rdata, {TimeW{1'b0}}} : {tag_q, time_q};
  assign m_re    = cmd_i.head_rd || cmd_i.dump_rd || cmd_i.dump_next;
  assign s_we    = cmd_i.exec && is_enq && !can_push && spill_space;

  always_comb begin
    priority if (cmd_i.head_rd) begin
      m_raddr = head_q;
    end else if (cmd_i.dump_next) begin
      m_raddr = dump_addr_inc;
    end else begin
      m_raddr = dump_addr_q;
    end
  end

  rqor_ram #(
    .WIDTH (MainW),
    .DEPTH (QUEUE_DEPTH)
  ) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (tail_q),
    .wdata_i (m_wdata),
    .re_i    (m_re),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  rqor_ram #(
    .WIDTH (TagW),
    .DEPTH (OVERFLOW_DEPTH)
  ) u_spill_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (stail),
    .wdata_i (tag_q),
    .re_i    (cmd_i.spill_rd),
    .raddr_i (shead_q),
    .rdata_o (s_rdata)
  );

  assign rd_tag  = m_rdata[MainW-1:TimeW];
  assign rd_time = m_rdata[TimeW-1:0];

  // control next state
  always_comb begin
    cap_d       = cap_q;
    head_d      = head_q;
    tail_d      = tail_q;
    mcnt_d      = mcnt_q;
    shead_d     = shead_q;
    scnt_d      = scnt_q;
    status_d    = status_q;
    dump_addr_d = dump_addr_q;
    dump_idx_d  = dump_idx_q;
    out_valid_d = out_valid_q;

    if (cfg_we_i) begin
      cap_d = cfg_wdata_i;
    end

    if (cmd_i.exec) begin
      status_d = rqor_pkg::STAT_OK;
      unique case (func_q)
        rqor_pkg::FUNC_ENQ: begin
          if (can_push) begin
            tail_d = tail_inc;
            mcnt_d = mcnt_q + 1'b1;
          end else if (spill_space) begin
            scnt_d   = scnt_q + 1'b1;
            status_d = rqor_pkg::STAT_DIVERT;
          end else begin
            status_d = rqor_pkg::STAT_LOST;
          end
        end
        rqor_pkg::FUNC_DEQ: begin
          if (main_empty) begin
            status_d = rqor_pkg::STAT_EMPTY;
          end else begin
            head_d = head_inc;
            mcnt_d = mcnt_q - 1'b1;
          end
        end
        rqor_pkg::FUNC_DUMP: begin
          if (main_empty) begin
            status_d = rqor_pkg::STAT_EMPTY;
          end
          dump_addr_d = head_q;
          dump_idx_d  = '0;
        end
        default: begin
          status_d = rqor_pkg::STAT_OK;
        end
      endcase
    end

    if (cmd_i.refill_wr) begin
      tail_d  = tail_inc;
      mcnt_d  = mcnt_q + 1'b1;
      shead_d = shead_inc;
      scnt_d  = scnt_q - 1'b1;
    end

    if (cmd_i.dump_next) begin
      dump_addr_d = dump_addr_inc;
      dump_idx_d  = dump_idx_q + 1'b1;
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= rqor_pkg::CAP_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      mcnt_q      <= '0;
      shead_q     <= '0;
      scnt_q      <= '0;
      status_q    <= rqor_pkg::STAT_OK;
      dump_addr_q <= '0;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      mcnt_q      <= mcnt_d;
      shead_q     <= shead_d;
      scnt_q      <= scnt_d;
      status_q    <= status_d;
      dump_addr_q <= dump_addr_d;
      dump_idx_q  <= dump_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // front entry: head read or zero if empty; dump reuses its first (head) read
  always_comb begin
    if (cmd_i.emit_dump) begin
      sel_ftag  = (dump_idx_q == '0) ? rd_tag : front_tag_q;
      sel_ftime = (dump_idx_q == '0) ? rd_time : front_time_q;
    end else if (main_empty) begin
      sel_ftag  = '0;
      sel_ftime = '0;
    end else begin
      sel_ftag  = rd_tag;
      sel_ftime = rd_time;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      tag_q  <= passenger_tag_i[TagW-1:0];
      time_q <= service_time_i;
    end
    if (cmd_i.emit_dump && dump_idx_q == '0) begin
      front_tag_q  <= rd_tag;
      front_time_q <= rd_time;
    end
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.emit_dump ? rqor_pkg::STAT_OK : status_q;
      out_fvalid_q <= !main_empty;
      out_ftag_q   <= sel_ftag;
      out_ftime_q  <= sel_ftime;
      out_mcnt_q   <= mcnt_q;
      out_scnt_q   <= scnt_q;
      out_dtag_q   <= cmd_i.emit_dump ? rd_tag : '0;
      out_last_q   <= cmd_i.emit_dump ? dump_last : 1'b1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign front_valid_o    = out_fvalid_q;
  assign front_tag_o      = TagOutW'(out_ftag_q);
  assign front_time_o     = out_ftime_q;
  assign queue_count_o    = CntOutW'(out_mcnt_q);
  assign overflow_count_o = CntOutW'(out_scnt_q);
  assign dump_tag_o       = TagOutW'(out_dtag_q);
  assign last_o           = out_last_q;

endmodule

// File: hw/rtl/ring_queue_with_overflow_refill.sv
// Top level of the ring queue with overflow refill: controller plus datapath.
// Depends on rqor_pkg, rqor_ctrl, rqor_dp (and rqor_ram through rqor_dp).
//
// One item is worked at a time. Enqueue, dequeue, query and an empty dump
// pass the execute, front read and front output states, the result entering
// the output register from the front output state. Refill moves overflow ids
// to the main queue until the overflow is empty or the main queue is full,
// each move reading the overflow RAM and then writing the main RAM, and ends
// with a final check. A non-empty dump makes one main RAM read per result.
// The output register lets a new item be accepted while the last result of
// the previous one still waits; a stalled output holds the work in place.
module ring_queue_with_overflow_refill #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int OVERFLOW_DEPTH = 16,
  parameter int TAG_BITS       = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rqor_pkg::CFG_BITS-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rqor_pkg::FUNC_BITS-1:0]     func_i,
  input  logic [rqor_pkg::TAG_PORT_BITS-1:0] passenger_tag_i,
  input  logic [rqor_pkg::TIME_BITS-1:0]     service_time_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rqor_pkg::STAT_BITS-1:0]     status_o,
  output logic                               front_valid_o,
  output logic [rqor_pkg::TAG_PORT_BITS-1:0] front_tag_o,
  output logic [rqor_pkg::TIME_BITS-1:0]     front_time_o,
  output logic [rqor_pkg::COUNT_BITS-1:0]    queue_count_o,
  output logic [rqor_pkg::COUNT_BITS-1:0]    overflow_count_o,
  output logic [rqor_pkg::TAG_PORT_BITS-1:0] dump_tag_o,
  output logic                               last_o
);

  rqor_pkg::cmd_t cmd;
  rqor_pkg::sts_t sts;

  rqor_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rqor_dp #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .OVERFLOW_DEPTH (OVERFLOW_DEPTH),
    .TAG_BITS       (TAG_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .func_i           (func_i),
    .passenger_tag_i  (passenger_tag_i),
    .service_time_i   (service_time_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .front_valid_o    (front_valid_o),
    .front_tag_o      (front_tag_o),
    .front_time_o     (front_time_o),
    .queue_count_o    (queue_count_o),
    .overflow_count_o (overflow_count_o),
    .dump_tag_o       (dump_tag_o),
    .last_o           (last_o)
  );

endmodule

// File: hw/rtl/rqor_chk.sv
// Port-level checker for the ring queue and its bind to the top level.
// Depends on rqor_pkg and ring_queue_with_overflow_refill_assert.svh.
`include "ring_queue_with_overflow_refill_assert.svh"

module rqor_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_i,
  input logic                               out_valid_i,
  input logic                               out_stall_i,
  input logic [rqor_pkg::STAT_BITS-1:0]     status_i,
  input logic                               front_valid_i,
  input logic [rqor_pkg::TAG_PORT_BITS-1:0] front_tag_i,
  input logic [rqor_pkg::TIME_BITS-1:0]     front_time_i,
  input logic [rqor_pkg::COUNT_BITS-1:0]    queue_count_i,
  input logic                               last_i
);

  `RQOR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(status_i) && $stable(front_tag_i) && $stable(last_i))
  `RQOR_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_i, in_stall_i)
  `RQOR_ASSERT_NOW(a_front_matches_count, clk_i, rst_ni, out_valid_i, front_valid_i == (queue_count_i != '0))
  `RQOR_ASSERT_NOW(a_empty_front_zero, clk_i, rst_ni, out_valid_i && !front_valid_i, front_tag_i == '0 && front_time_i == '0)
  `RQOR_ASSERT_NOW(a_empty_status, clk_i, rst_ni, out_valid_i && status_i == rqor_pkg::STAT_EMPTY, !front_valid_i && last_i)

endmodule

bind ring_queue_with_overflow_refill rqor_chk u_rqor_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_i    (in_stall_o),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_i      (status_o),
  .front_valid_i (front_valid_o),
  .front_tag_i   (front_tag_o),
  .front_time_i  (front_time_o),
  .queue_count_i (queue_count_o),
  .last_i        (last_o)
);
